[rtl/svpm_pkg.sv]
// Shared types, constants and the log2 mantissa table for the stereo level meter.
// Used by every module of the meter; depends on nothing else.
`default_nettype none

package svpm_pkg;

  // Default sizing of the window and the sample word.
  localparam int WINDOW_DEF      = 2048;
  localparam int SAMPLE_BITS_DEF = 16;

  // Width of one squared 16-bit magnitude (at most 2^30).
  localparam int SQ_W = 31;

  // Log2 results in Q.8, signed dB differences and the dB product.
  localparam int LOG_W  = 16;
  localparam int D_W    = 18;
  localparam int K_W    = 19;
  localparam int MAG_W  = D_W - 1 + K_W;
  localparam int DIVN_W = MAG_W + 1 - 8;

  // Scale factors from log2 in Q.8 to dB in Q.24.
  localparam logic [K_W-1:0] K_RMS  = K_W'(197283);
  localparam logic [K_W-1:0] K_PEAK = K_W'(394566);

  // Display epsilon, 0.001 in Q0.16.
  localparam logic [15:0] EPS_Q16 = 16'd66;

  // Item opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RISE_GAIN  = 3'd0,
    REG_FALL_GAIN  = 3'd1,
    REG_HOLD_TICKS = 3'd2,
    REG_PEAK_FALL  = 3'd3,
    REG_FLOOR_DB   = 3'd4
  } cfg_reg_t;

  // Register reset values.
  localparam logic [15:0] RISE_GAIN_RST = 16'd28704;
  localparam logic [15:0] FALL_GAIN_RST = 16'd9690;
  localparam logic [7:0]  HOLD_RST      = 8'd28;
  localparam logic [15:0] PEAK_FALL_RST = 16'd682;
  localparam logic [6:0]  FLOOR_DB_RST  = 7'd48;

  typedef struct packed {
    logic               op;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               playing;
    logic               analyze;
  } in_t;

  typedef struct packed {
    logic [15:0] level_left;
    logic [15:0] level_right;
    logic [15:0] peak_left;
    logic [15:0] peak_right;
    logic        animating;
  } out_t;

  typedef struct packed {
    logic [15:0] rise_gain;
    logic [15:0] fall_gain;
    logic [7:0]  hold_ticks;
    logic [15:0] peak_fall_step;
    logic [6:0]  floor_db;
  } cfg_t;

  // Control from the merge stage to each lane.
  typedef struct packed {
    logic acc;
    logic start;
    logic playing;
    logic analyze;
    logic release_lane;
  } lane_ctrl_t;

  // Status from each lane to the merge stage.
  typedef struct packed {
    logic done;
    logic anim;
  } lane_stat_t;

  typedef logic [8:0] log_tab_t [256];

  // log2(1 + i/256) to 16 fraction bits by repeated squaring, rounded to 8 bits.
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] y;
    logic [16:0] r;
    for (int i = 0; i < 256; i++) begin
      y = 64'(256 + i) << 22;
      r = '0;
      for (int b = 0; b < 16; b++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd2 << 30)) begin
          r = r | 17'd1;
          y = y >> 1;
        end
      end
      t[i] = 9'((r + 17'd128) >> 8);
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

`default_nettype wire

[rtl/svpm_log2.sv]
// Iterative log2 in Q.8: one-bit-per-cycle leading-one search, then table lookup.
// Depends on svpm_pkg for LOG_W and LOG_TAB.
`default_nettype none

module svpm_log2 #(
  parameter int W = 43
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     x,
  output logic             done,
  output logic [svpm_pkg::LOG_W-1:0] res
);
  import svpm_pkg::*;

  localparam int EW = $clog2(W + 1);

  logic [W-1:0]     x_r;
  logic [EW-1:0]    e_r;
  logic             busy_r;
  logic             done_r;
  logic [LOG_W-1:0] res_r;

  logic [9:0]       f_rnd;
  logic             carry;
  logic [LOG_W-1:0] e_fin;
  logic [7:0]       idx;
  logic [LOG_W-1:0] res_nxt;

  // Round the leading one and the eight bits under it; a carry bumps the exponent.
  always_comb begin
    f_rnd   = {1'b0, x_r[W-1:W-9]} + {9'd0, x_r[W-10]};
    carry   = f_rnd[9];
    e_fin   = LOG_W'(e_r) + LOG_W'(carry);
    idx     = carry ? 8'd0 : f_rnd[7:0];
    res_nxt = {e_fin[LOG_W-9:0], 8'd0} + LOG_W'(LOG_TAB[idx]);
  end

  // Shift left until the leading one reaches the top bit or the exponent reaches zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!(x_r[W-1] == 1'b0 && e_r != '0)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      e_r <= EW'(W - 1);
    end else if (busy_r) begin
      if (x_r[W-1] == 1'b0 && e_r != '0) begin
        x_r <= {x_r[W-2:0], 1'b0};
        e_r <= e_r - EW'(1);
      end else begin
        res_r <= res_nxt;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

[rtl/svpm_div.sv]
// Restoring divider, one quotient bit per cycle, by the 7-bit dB floor.
// Depends on svpm_pkg for DIVN_W.
`default_nettype none

module svpm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [svpm_pkg::DIVN_W-1:0] num,
  input  logic [6:0]                  den,
  output logic                        done,
  output logic [svpm_pkg::DIVN_W-1:0] quo
);
  import svpm_pkg::*;

  localparam int CW = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] quo_r;
  logic [6:0]        rem_r;
  logic [6:0]        den_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [7:0]        trial;
  logic              ge;
  logic [7:0]        diff;

  // Bring down the next dividend bit and try the subtract.
  always_comb begin
    trial = {rem_r, quo_r[DIVN_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIVN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVN_W-2:0], ge};
      rem_r <= ge ? diff[6:0] : trial[6:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

[rtl/svpm_lane.sv]
// One meter channel: window accumulators, dB targets, easing and peak hold.
// Depends on svpm_pkg, svpm_log2 and svpm_div.
`default_nettype none

module svpm_lane #(
  parameter int SUM_W       = 43,
  parameter int CNT_W       = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [15:0]      sample,
  input  logic [CNT_W-1:0]        count,
  input  svpm_pkg::lane_ctrl_t    ctrl,
  input  svpm_pkg::cfg_t          cfg,
  output svpm_pkg::lane_stat_t    stat,
  output logic [15:0]             level,
  output logic [15:0]             peak
);
  import svpm_pkg::*;

  localparam logic [D_W-1:0] RMS_OFF = D_W'(512 * (SAMPLE_BITS_DEF - 1));
  localparam logic [D_W-1:0] PK_OFF  = D_W'(256 * (SAMPLE_BITS_DEF - 1));

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_LOGS  = 11'b00000000010,
    ST_LOGC  = 11'b00000000100,
    ST_LOGP  = 11'b00000001000,
    ST_MULR  = 11'b00000010000,
    ST_DIVR  = 11'b00000100000,
    ST_MULP  = 11'b00001000000,
    ST_DIVP  = 11'b00010000000,
    ST_EASE  = 11'b00100000000,
    ST_APPLY = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } lane_state_t;

  lane_state_t        state_r;
  logic [SUM_W-1:0]   sum_r;
  logic [15:0]        apeak_r;
  logic [15:0]        tl_r, tp_r, ml_r, mp_r;
  logic [7:0]         hold_r;
  logic               ana_r;
  logic               launched_r;
  logic [LOG_W-1:0]   lsum_r;
  logic [D_W-1:0]     drms_r, dpk_r;
  logic [MAG_W-1:0]   mag_r;
  logic               pos_r;
  logic [31:0]        prod_r;
  logic               up_r;

  logic [15:0]        mag16;
  logic [31:0]        sq;
  logic               log_start, log_done;
  logic [SUM_W-1:0]   log_x;
  logic [LOG_W-1:0]   log_res;
  logic               div_start, div_done;
  logic [DIVN_W-1:0]  div_num, div_quo;
  logic [6:0]         fl;
  logic [MAG_W:0]     rnd;
  logic [15:0]        norm;
  logic [D_W-2:0]     nd;
  logic               up;
  logic [15:0]        diff;
  logic [32:0]        step_sum;
  logic [15:0]        step;
  logic [15:0]        ml_nxt;
  logic [15:0]        p_fall;
  logic [15:0]        ldiff;

  // Magnitude and square of the incoming sample.
  always_comb begin
    mag16 = sample[15] ? 16'(17'h10000 - {1'b0, sample}) : sample;
    sq    = mag16 * mag16;
  end

  // Operand selection for the shared log2 unit.
  always_comb begin
    case (state_r)
      ST_LOGC: log_x = SUM_W'(count);
      ST_LOGP: log_x = SUM_W'(apeak_r);
      default: log_x = sum_r;
    endcase
    log_start = (state_r == ST_LOGS || state_r == ST_LOGC || state_r == ST_LOGP)
                && !launched_r;
    div_start = (state_r == ST_DIVR || state_r == ST_DIVP) && !launched_r;
  end

  // Rounded divide by floor_db*256 is the divide of the rounded value >> 8.
  always_comb begin
    fl      = (cfg.floor_db == 7'd0) ? 7'd1 : cfg.floor_db;
    rnd     = {1'b0, mag_r} + (MAG_W + 1)'({fl, 7'd0});
    div_num = rnd[MAG_W:8];
    if (pos_r) begin
      norm = 16'hFFFF;
    end else if (div_quo >= DIVN_W'(65536)) begin
      norm = 16'd0;
    end else if (div_quo == '0) begin
      norm = 16'hFFFF;
    end else begin
      norm = 16'(17'h10000 - div_quo[16:0]);
    end
  end

  // Negated dB difference for the current multiply.
  always_comb begin
    if (state_r == ST_MULP) begin
      nd = (D_W - 1)'(-dpk_r);
    end else begin
      nd = (D_W - 1)'(-drms_r);
    end
  end

  // Easing step and the peak drop.
  always_comb begin
    up       = tl_r > ml_r;
    diff     = up ? (tl_r - ml_r) : (ml_r - tl_r);
    step_sum = {1'b0, prod_r} + 33'd32768;
    step     = step_sum[31:16];
    ml_nxt   = up_r ? (ml_r + step) : (ml_r - step);
    p_fall   = (mp_r > cfg.peak_fall_step) ? (mp_r - cfg.peak_fall_step) : 16'd0;
    ldiff    = (ml_r > tl_r) ? (ml_r - tl_r) : (tl_r - ml_r);
  end

  svpm_log2 #(.W(SUM_W)) u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .res   (log_res)
  );

  svpm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (fl),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Lane sequencer and state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      launched_r <= 1'b0;
      sum_r      <= '0;
      apeak_r    <= '0;
      tl_r       <= '0;
      tp_r       <= '0;
      ml_r       <= '0;
      mp_r       <= '0;
      hold_r     <= '0;
      ana_r      <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (ctrl.acc) begin
            sum_r <= sum_r + SUM_W'(sq);
            if (mag16 > apeak_r) begin
              apeak_r <= mag16;
            end
          end
          if (ctrl.start) begin
            ana_r <= ctrl.playing && ctrl.analyze;
            if (ctrl.playing && ctrl.analyze) begin
              state_r <= ST_LOGS;
            end else begin
              if (!ctrl.playing) begin
                tl_r <= '0;
                tp_r <= '0;
              end
              state_r <= ST_EASE;
            end
          end
        end
        ST_LOGS: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (log_done) begin
            launched_r <= 1'b0;
            lsum_r     <= log_res;
            state_r    <= ST_LOGC;
          end
        end
        ST_LOGC: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (log_done) begin
            launched_r <= 1'b0;
            drms_r     <= D_W'(lsum_r) - D_W'(log_res) - RMS_OFF;
            state_r    <= ST_LOGP;
          end
        end
        ST_LOGP: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (log_done) begin
            launched_r <= 1'b0;
            dpk_r      <= D_W'(log_res) - PK_OFF;
            state_r    <= ST_MULR;
          end
        end
        ST_MULR: begin
          pos_r   <= !drms_r[D_W-1];
          mag_r   <= MAG_W'(nd) * MAG_W'(K_RMS);
          state_r <= ST_DIVR;
        end
        ST_DIVR: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (div_done) begin
            launched_r <= 1'b0;
            tl_r       <= (sum_r == '0) ? 16'd0 : norm;
            state_r    <= ST_MULP;
          end
        end
        ST_MULP: begin
          pos_r   <= !dpk_r[D_W-1];
          mag_r   <= MAG_W'(nd) * MAG_W'(K_PEAK);
          state_r <= ST_DIVP;
        end
        ST_DIVP: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (div_done) begin
            launched_r <= 1'b0;
            tp_r       <= (apeak_r == '0) ? 16'd0 : norm;
            state_r    <= ST_EASE;
          end
        end
        ST_EASE: begin
          up_r    <= up;
          prod_r  <= diff * (up ? cfg.rise_gain : cfg.fall_gain);
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          ml_r <= ml_nxt;
          if (tp_r > mp_r) begin
            mp_r   <= tp_r;
            hold_r <= cfg.hold_ticks;
          end else if (hold_r != 8'd0) begin
            hold_r <= hold_r - 8'd1;
          end else begin
            mp_r <= (p_fall > ml_nxt) ? p_fall : ml_nxt;
          end
          if (ana_r) begin
            sum_r   <= '0;
            apeak_r <= '0;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (ctrl.release_lane) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign stat.done = (state_r == ST_DONE);
  assign stat.anim = (ml_r > EPS_Q16) || (mp_r > EPS_Q16) || (ldiff > EPS_Q16);
  assign level     = ml_r;
  assign peak      = mp_r;

endmodule

`default_nettype wire

[rtl/stereo_level_peak_meter.sv]
// Stereo level and peak meter: two channel lanes side by side and a merge stage.
// Depends on svpm_pkg and svpm_lane.
//
// Usage: words on the input channel are either sample pairs (op = sample) or
// meter ticks (op = tick). A sample pair adds to each channel's window of at
// most WINDOW pairs; it gives no result word. A tick gives exactly one result
// word with the eased levels, the held peaks and the animating flag.
// Flow: sample pairs are taken at one per cycle while no tick is in work. A tick
// with analyze set while playing runs three log2 evaluations per lane, each a
// bit-serial leading-one search, and two restoring divides before its result
// word; any other tick goes straight to the easing step. The input stalls
// while a tick is in work, and a tick is also held off while an earlier result
// word is still waiting; sample pairs still flow in that case.
// A stalled result word is held unchanged until taken.
// Reset clears all windows, targets, meters and the count, and restores the
// configuration defaults. Configuration is to be written by the user only
// while idle; the block itself does not enforce it.
`default_nettype none

module stereo_level_peak_meter #(
  parameter int WINDOW      = svpm_pkg::WINDOW_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  svpm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output svpm_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_idx,
  input  logic [15:0]     cfg_data
);
  import svpm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SQ_W + CNT_W;

  cfg_t             cfg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             ana_r;
  logic             out_valid_r;
  out_t             out_data_r;

  logic             in_acc;
  logic             tick_acc;
  logic             room;
  logic             both_done;
  lane_ctrl_t       ctrl;
  lane_stat_t       stat_l, stat_r;
  logic [15:0]      lvl_l, lvl_r, pk_l, pk_r;

  // Input handshake and lane control.
  always_comb begin
    in_stall  = busy_r || (out_valid_r && (in_data.op == OP_TICK));
    in_acc    = in_valid && !in_stall;
    tick_acc  = in_acc && (in_data.op == OP_TICK);
    room      = cnt_r < CNT_W'(WINDOW);
    both_done = busy_r && stat_l.done && stat_r.done;
    ctrl.acc          = in_acc && (in_data.op == OP_SAMPLE) && room;
    ctrl.start        = tick_acc;
    ctrl.playing      = in_data.playing;
    ctrl.analyze      = in_data.analyze;
    ctrl.release_lane = both_done;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_gain      <= RISE_GAIN_RST;
      cfg_r.fall_gain      <= FALL_GAIN_RST;
      cfg_r.hold_ticks     <= HOLD_RST;
      cfg_r.peak_fall_step <= PEAK_FALL_RST;
      cfg_r.floor_db       <= FLOOR_DB_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RISE_GAIN:  cfg_r.rise_gain      <= cfg_data;
        REG_FALL_GAIN:  cfg_r.fall_gain      <= cfg_data;
        REG_HOLD_TICKS: cfg_r.hold_ticks     <= cfg_data[7:0];
        REG_PEAK_FALL:  cfg_r.peak_fall_step <= cfg_data;
        REG_FLOOR_DB:   cfg_r.floor_db       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Window count, tick tracking and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      ana_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.acc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (tick_acc) begin
        busy_r <= 1'b1;
        ana_r  <= in_data.playing && in_data.analyze;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (both_done) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        if (ana_r) begin
          cnt_r <= '0;
        end
      end
    end
  end

  // Merge what the two lanes found into one result word.
  always_ff @(posedge clk) begin
    if (both_done) begin
      out_data_r.level_left  <= lvl_l;
      out_data_r.level_right <= lvl_r;
      out_data_r.peak_left   <= pk_l;
      out_data_r.peak_right  <= pk_r;
      out_data_r.animating   <= stat_l.anim || stat_r.anim;
    end
  end

  svpm_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (in_data.left),
    .count  (cnt_r),
    .ctrl   (ctrl),
    .cfg    (cfg_r),
    .stat   (stat_l),
    .level  (lvl_l),
    .peak   (pk_l)
  );

  svpm_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (in_data.right),
    .count  (cnt_r),
    .ctrl   (ctrl),
    .cfg    (cfg_r),
    .stat   (stat_r),
    .level  (lvl_r),
    .peak   (pk_r)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/svpm_chk.sv]
// Port-level checker for the stereo level meter, bound to the top level.
// Depends on svpm_pkg and stereo_level_peak_meter.
`default_nettype none

module svpm_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input svpm_pkg::out_t out_data
);
  import svpm_pkg::*;

  // A waiting result word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // No result word right after reset.
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A quiet meter has every level and peak at or under epsilon.
  a_anim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.animating |->
      out_data.level_left <= EPS_Q16 && out_data.level_right <= EPS_Q16 &&
      out_data.peak_left <= EPS_Q16 && out_data.peak_right <= EPS_Q16)
    else $error("animating clear with a visible meter");

endmodule

bind stereo_level_peak_meter svpm_chk u_svpm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[dv/tb_stereo_level_peak_meter.sv]
// Self-checking testbench for the stereo level and peak meter.
// Depends on svpm_pkg and the stereo_level_peak_meter RTL; it needs no other file.
// A directed table and then random sample and tick words are checked against a predictor.
`default_nettype none

module tb_stereo_level_peak_meter;
  import svpm_pkg::*;

  localparam int WIN    = 2048;
  localparam int FS_LOG = 256 * 15;
  localparam int K_R    = 197283;
  localparam int K_P    = 394566;
  localparam int EPS    = 66;
  localparam int SETTLE = 300;

  typedef struct {
    in_t  w;
    int   reps;
    bit   typed;
    out_t t;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  stereo_level_peak_meter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: configuration, window, targets and meters.
  int unsigned     log_frac [256];
  int unsigned     g_rise, g_fall, g_hold, g_fall_step, g_floor;
  longint unsigned win_sq [2];
  int unsigned     win_pk [2];
  int unsigned     win_n;
  int unsigned     tgt_lvl [2], tgt_pk [2], mtr_lvl [2], mtr_pk [2], hold_cnt [2];

  out_t meter_word_q [$];
  int   errors = 0;
  int   n_samples = 0, n_ticks = 0, n_results = 0, n_cfg = 0;
  int   send_idle_pct = 0, recv_idle_pct = 0;
  int   hold_asked = 0, hold_seen = 0, stall_run = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // log2(1 + i/256) by repeated squaring, truncated to 16 bits and rounded to 8.
  task automatic make_log_frac();
    longint unsigned y;
    int unsigned     r;
    for (int i = 0; i < 256; i++) begin
      y = longint'(256 + i) << 22;
      r = 0;
      for (int b = 0; b < 16; b++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd2 << 30)) begin
          r = r | 1;
          y = y >> 1;
        end
      end
      log_frac[i] = (r + 128) >> 8;
    end
  endtask

  function automatic longint log2_q8(input longint unsigned x);
    int              e;
    longint unsigned f;
    e = 63;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= 8) begin
      f = x >> (e - 8);
      if (e >= 9) f += (x >> (e - 9)) & 1;
      if (f >= 512) begin
        f = 256;
        e++;
      end
    end else begin
      f = x << (8 - e);
    end
    return longint'(e) * 256 + log_frac[(f - 256) & 255];
  endfunction

  // Maps a log2 difference to the 0..1 scale above the floor.
  function automatic int unsigned db_to_scale(input longint d, input longint k);
    longint          db;
    longint unsigned mag, den, drop;
    db = d * k;
    if (db >= 0) return 65535;
    mag = -db;
    den = longint'(g_floor == 0 ? 1 : g_floor) << 8;
    drop = (mag + den / 2) / den;
    if (drop >= 65536) return 0;
    if (drop == 0) return 65535;
    return 32'(65536 - drop);
  endfunction

  function automatic int unsigned ease_toward(input int unsigned lvl, input int unsigned tgt);
    longint unsigned step;
    if (tgt > lvl) begin
      step = (longint'(tgt - lvl) * g_rise + 32768) >> 16;
      return 32'(lvl + step);
    end
    step = (longint'(lvl - tgt) * g_fall + 32768) >> 16;
    return 32'(lvl - step);
  endfunction

  task automatic meter_reset();
    g_rise = RISE_GAIN_RST;
    g_fall = FALL_GAIN_RST;
    g_hold = HOLD_RST;
    g_fall_step = PEAK_FALL_RST;
    g_floor = FLOOR_DB_RST;
    for (int c = 0; c < 2; c++) begin
      win_sq[c] = 0; win_pk[c] = 0; tgt_lvl[c] = 0; tgt_pk[c] = 0;
      mtr_lvl[c] = 0; mtr_pk[c] = 0; hold_cnt[c] = 0;
    end
    win_n = 0;
  endtask

  // Advances the meter by one accepted word; returns 1 with the result for a tick.
  task automatic meter_step(input in_t w, output bit has_word, output out_t r);
    int unsigned a [2];
    int unsigned p, diff;
    bit          anim;
    has_word = 1'b0;
    r = '0;
    anim = 1'b0;
    if (w.op == OP_SAMPLE) begin
      if (win_n < WIN) begin
        a[0] = w.left[15] ? 32'h10000 - w.left : w.left;
        a[1] = w.right[15] ? 32'h10000 - w.right : w.right;
        for (int c = 0; c < 2; c++) begin
          win_sq[c] += longint'(a[c]) * a[c];
          if (a[c] > win_pk[c]) win_pk[c] = a[c];
        end
        win_n++;
      end
      return;
    end
    if (w.playing) begin
      if (w.analyze) begin
        for (int c = 0; c < 2; c++) begin
          if (win_n == 0 || win_sq[c] == 0) tgt_lvl[c] = 0;
          else tgt_lvl[c] = db_to_scale(log2_q8(win_sq[c]) - log2_q8(win_n) - 2 * FS_LOG, K_R);
          if (win_n == 0 || win_pk[c] == 0) tgt_pk[c] = 0;
          else tgt_pk[c] = db_to_scale(log2_q8(win_pk[c]) - FS_LOG, K_P);
          win_sq[c] = 0;
          win_pk[c] = 0;
        end
        win_n = 0;
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        tgt_lvl[c] = 0;
        tgt_pk[c] = 0;
      end
    end
    for (int c = 0; c < 2; c++) begin
      mtr_lvl[c] = ease_toward(mtr_lvl[c], tgt_lvl[c]);
      if (tgt_pk[c] > mtr_pk[c]) begin
        mtr_pk[c] = tgt_pk[c];
        hold_cnt[c] = g_hold;
      end else if (hold_cnt[c] > 0) begin
        hold_cnt[c]--;
      end else begin
        p = mtr_pk[c] > g_fall_step ? mtr_pk[c] - g_fall_step : 0;
        mtr_pk[c] = p > mtr_lvl[c] ? p : mtr_lvl[c];
      end
      diff = mtr_lvl[c] > tgt_lvl[c] ? mtr_lvl[c] - tgt_lvl[c] : tgt_lvl[c] - mtr_lvl[c];
      if (mtr_lvl[c] > EPS || mtr_pk[c] > EPS || diff > EPS) anim = 1'b1;
    end
    r.level_left = 16'(mtr_lvl[0]);
    r.level_right = 16'(mtr_lvl[1]);
    r.peak_left = 16'(mtr_pk[0]);
    r.peak_right = 16'(mtr_pk[1]);
    r.animating = anim;
    has_word = 1'b1;
  endtask

  // Offers one word, waits for it to be taken, then records what it should produce.
  task automatic send_word(input in_t w, input bit typed, input out_t typed_word);
    bit   has_word;
    out_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    meter_step(w, has_word, pred);
    if (w.op == OP_SAMPLE) n_samples++;
    else n_ticks++;
    if (has_word) meter_word_q.push_back(typed ? typed_word : pred);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_RISE_GAIN:  g_rise = val;
      REG_FALL_GAIN:  g_fall = val;
      REG_HOLD_TICKS: g_hold = val[7:0];
      REG_PEAK_FALL:  g_fall_step = val;
      REG_FLOOR_DB:   g_floor = val[6:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // Waits until every tick result has come back and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (meter_word_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return ($urandom & 1) ? -(16'($urandom) >> $urandom_range(1, 15))
                               : 16'($urandom) >> $urandom_range(1, 15);
      2: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'($urandom) >> 12;
    endcase
  endfunction

  function automatic stim_row_t row(input logic op, input logic [15:0] l, input logic [15:0] r,
                                    input logic pl, input logic an, input int reps);
    stim_row_t s;
    s.w.op = op;
    s.w.left = l;
    s.w.right = r;
    s.w.playing = pl;
    s.w.analyze = an;
    s.reps = reps;
    s.typed = 1'b0;
    s.t = '0;
    return s;
  endfunction

  // Receiver: random stalls by mode, plus one long hold-off on request.
  always @(posedge clk) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      stall_run <= 800;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker: each taken word against the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (meter_word_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        e = meter_word_q.pop_front();
        if (out_data.level_left !== e.level_left)
          report_mismatch($sformatf("level_left %0d, want %0d", out_data.level_left, e.level_left));
        if (out_data.level_right !== e.level_right)
          report_mismatch($sformatf("level_right %0d, want %0d", out_data.level_right,
                                    e.level_right));
        if (out_data.peak_left !== e.peak_left)
          report_mismatch($sformatf("peak_left %0d, want %0d", out_data.peak_left, e.peak_left));
        if (out_data.peak_right !== e.peak_right)
          report_mismatch($sformatf("peak_right %0d, want %0d", out_data.peak_right,
                                    e.peak_right));
        if (out_data.animating !== e.animating)
          report_mismatch($sformatf("animating %0b, want %0b", out_data.animating, e.animating));
      end
    end
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", meter_word_q.size());
    $display("[stereo_level_peak_meter] ERROR");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t s;
    in_t       w;
    out_t      none;
    int        pct;
    none = '0;
    make_log_frac();
    meter_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, every tick flavor, empty and full windows, hold and fall.
    s = row(OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, 1);
    s.typed = 1'b1;
    s.t = '0;
    rows.push_back(s);
    rows.push_back(row(OP_SAMPLE, 16'h8000, 16'h8000, 1'b0, 1'b0, 1));
    s = row(OP_TICK, 16'h0000, 16'h0000, 1'b1, 1'b1, 1);
    s.typed = 1'b1;
    s.t = '{16'd28704, 16'd28704, 16'd65535, 16'd65535, 1'b1};
    rows.push_back(s);
    rows.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1'b1, 1'b1, 1));
    rows.push_back(row(OP_SAMPLE, 16'h7fff, 16'h8001, 1'b1, 1'b1, 1));
    rows.push_back(row(OP_SAMPLE, 16'h0001, 16'hffff, 1'b0, 1'b1, 1));
    rows.push_back(row(OP_TICK, 16'hffff, 16'hffff, 1'b1, 1'b0, 1));
    rows.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, 1));
    rows.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1'b1, 1'b1, 1));
    rows.push_back(row(OP_SAMPLE, 16'h0000, 16'h0000, 1'b0, 1'b0, 3));
    rows.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1'b1, 1'b1, 1));
    rows.push_back(row(OP_SAMPLE, 16'h0001, 16'h0000, 1'b0, 1'b0, 1));
    rows.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1'b1, 1'b1, 1));
    rows.push_back(row(OP_SAMPLE, 16'd12345, -16'sd6789, 1'b0, 1'b0, WIN + 40));
    rows.push_back(row(OP_SAMPLE, 16'h8000, 16'h7fff, 1'b0, 1'b0, 1));
    rows.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1'b1, 1'b1, 1));
    rows.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 40));
    rows.push_back(row(OP_SAMPLE, 16'hffff, 16'h0001, 1'b0, 1'b0, 1));
    rows.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1'b1, 1'b1, 1));
    send_idle_pct = 27;
    recv_idle_pct = 59;
    foreach (rows[i])
      for (int k = 0; k < rows[i].reps; k++) send_word(rows[i].w, rows[i].typed, rows[i].t);

    // Random phases, each under a new configuration written while idle.
    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_RISE_GAIN, 16'd0);
          write_reg(REG_FALL_GAIN, 16'hffff);
          write_reg(REG_HOLD_TICKS, 16'd0);
          write_reg(REG_PEAK_FALL, 16'd0);
          write_reg(REG_FLOOR_DB, 16'd1);
        end
        1: begin
          write_reg(REG_RISE_GAIN, 16'hffff);
          write_reg(REG_FALL_GAIN, 16'd0);
          write_reg(REG_HOLD_TICKS, 16'd255);
          write_reg(REG_PEAK_FALL, 16'hffff);
          write_reg(REG_FLOOR_DB, 16'd96);
        end
        2: begin
          write_reg(REG_FLOOR_DB, 16'd0);
          write_reg(REG_FALL_GAIN, 16'd9690);
          write_reg(REG_PEAK_FALL, 16'd682);
          write_reg(cfg_reg_t'(3'd5), 16'($urandom));
          write_reg(cfg_reg_t'(3'd7), 16'($urandom));
        end
        3: begin
          write_reg(REG_FLOOR_DB, 16'h007f);
          write_reg(REG_HOLD_TICKS, 16'hff03);
          write_reg(REG_RISE_GAIN, 16'($urandom));
        end
        default: begin
          write_reg(REG_RISE_GAIN, 16'($urandom));
          write_reg(REG_FALL_GAIN, 16'($urandom));
          write_reg(REG_HOLD_TICKS, 16'($urandom_range(0, 40)));
          write_reg(REG_PEAK_FALL, 16'($urandom_range(0, 4000)));
          write_reg(REG_FLOOR_DB, 16'($urandom_range(1, 96)));
        end
      endcase
      cfg_we <= 1'b0;
      send_idle_pct = ph < 2 ? 27 : (ph < 4 ? 59 : 0);
      recv_idle_pct = ph < 2 ? 59 : (ph < 4 ? 27 : 0);
      if (ph == 3) hold_asked++;
      for (int n = 0; n < 200; n++) begin
        w.op = ($urandom_range(7) == 0) ? OP_TICK : OP_SAMPLE;
        w.left = pick_sample();
        w.right = pick_sample();
        pct = $urandom_range(99);
        w.playing = (w.op == OP_TICK) ? (pct < 85) : 1'($urandom);
        w.analyze = (w.op == OP_TICK) ? ($urandom_range(99) < 70) : 1'($urandom);
        send_word(w, 1'b0, none);
      end
    end

    wait_idle();
    $display("covered %0d sample pairs, %0d ticks, %0d result words, %0d register writes",
             n_samples, n_ticks, n_results, n_cfg);
    if (errors == 0) begin
      $display("[stereo_level_peak_meter] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[stereo_level_peak_meter] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[stereo_level_peak_meter.f]
rtl/svpm_pkg.sv
rtl/svpm_log2.sv
rtl/svpm_div.sv
rtl/svpm_lane.sv
rtl/stereo_level_peak_meter.sv
rtl/svpm_chk.sv
dv/tb_stereo_level_peak_meter.sv
